// ----- rtl/xtb_pkg.sv -----
// Shared types, character codes and helpers for the xyz text bounds scanner.
package xtb_pkg;

    localparam int NUM_AXES = 3;

    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_VTAB    = 8'd11;
    localparam logic [7:0] CH_FFEED   = 8'd12;
    localparam logic [7:0] CH_CR      = 8'd13;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_PLUS    = 8'd43;
    localparam logic [7:0] CH_MINUS   = 8'd45;
    localparam logic [7:0] CH_ZERO    = 8'd48;
    localparam logic [7:0] CH_NINE    = 8'd57;

    typedef enum logic [1:0] {
        PH_BLANK = 2'd0,
        PH_SIGN  = 2'd1,
        PH_DIGIT = 2'd2,
        PH_STOP  = 2'd3
    } phase_t;

    typedef struct packed {
        logic is_digit;
        logic is_blank;
        logic is_sign;
        logic is_minus;
        logic is_tab;
        logic is_newline;
    } char_class_t;

    typedef struct packed {
        logic        fire;
        char_class_t cls;
        logic [3:0]  digit;
    } char_step_t;

    function automatic char_class_t classify(input logic [7:0] c);
        char_class_t r;
        r.is_digit   = (c >= CH_ZERO) && (c <= CH_NINE);
        r.is_blank   = (c == CH_SPACE) || (c == CH_VTAB) || (c == CH_FFEED) || (c == CH_CR);
        r.is_sign    = (c == CH_PLUS) || (c == CH_MINUS);
        r.is_minus   = (c == CH_MINUS);
        r.is_tab     = (c == CH_TAB);
        r.is_newline = (c == CH_NEWLINE);
        return r;
    endfunction

endpackage

// ----- rtl/xtb_field_parser.sv -----
// Decimal field conversion, field indexing and line capture.
module xtb_field_parser #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  xtb_pkg::char_step_t           step,
    output logic                          line_fire,
    output logic signed [COORD_WIDTH-1:0] pt [xtb_pkg::NUM_AXES]
);

    localparam int NA = xtb_pkg::NUM_AXES;

    xtb_pkg::phase_t        phase_reg, phase_next;
    logic [COORD_WIDTH-1:0] acc_reg, acc_next;
    logic                   neg_reg, neg_next;
    logic [1:0]             fidx_reg, fidx_next;
    logic [COORD_WIDTH-1:0] cap_reg  [NA];
    logic [COORD_WIDTH-1:0] cap_next [NA];

    logic [COORD_WIDTH-1:0] acc_x10;
    logic [COORD_WIDTH-1:0] digit_ext;
    logic                   field_end;
    logic                   slot_free;

    assign acc_x10   = (acc_reg << 3) + (acc_reg << 1);
    assign digit_ext = COORD_WIDTH'(step.digit);
    assign field_end = step.fire && (step.cls.is_tab || step.cls.is_newline);
    assign slot_free = (fidx_reg < 2'(NA));
    assign line_fire = step.fire && step.cls.is_newline;

    // field values as of the end of the current line
    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            if (slot_free && (fidx_reg == 2'(i)))
                pt[i] = $signed(acc_reg);
            else
                pt[i] = $signed(cap_reg[i]);
        end
    end

    // conversion phase
    always_comb
    begin
        phase_next = phase_reg;
        if (field_end)
            phase_next = xtb_pkg::PH_BLANK;
        else if (step.fire && (phase_reg != xtb_pkg::PH_STOP))
        begin
            if (step.cls.is_digit)
                phase_next = xtb_pkg::PH_DIGIT;
            else if ((phase_reg == xtb_pkg::PH_BLANK) && step.cls.is_blank)
                phase_next = xtb_pkg::PH_BLANK;
            else if ((phase_reg == xtb_pkg::PH_BLANK) && step.cls.is_sign)
                phase_next = xtb_pkg::PH_SIGN;
            else
                phase_next = xtb_pkg::PH_STOP;
        end
    end

    // accumulator, sign and capture
    always_comb
    begin
        acc_next  = acc_reg;
        neg_next  = neg_reg;
        fidx_next = fidx_reg;
        for (int i = 0; i < NA; i++)
            cap_next[i] = cap_reg[i];

        if (field_end)
        begin
            acc_next = '0;
            neg_next = 1'b0;
            if (step.cls.is_newline)
            begin
                fidx_next = '0;
                for (int i = 0; i < NA; i++)
                    cap_next[i] = '0;
            end
            else if (slot_free)
            begin
                fidx_next = fidx_reg + 2'd1;
                for (int i = 0; i < NA; i++)
                begin
                    if (fidx_reg == 2'(i))
                        cap_next[i] = acc_reg;
                end
            end
        end
        else if (step.fire && (phase_reg != xtb_pkg::PH_STOP))
        begin
            if (step.cls.is_digit)
            begin
                // negative fields accumulate negated, so no final negate
                if (neg_reg)
                    acc_next = acc_x10 - digit_ext;
                else
                    acc_next = acc_x10 + digit_ext;
            end
            else if ((phase_reg == xtb_pkg::PH_BLANK) && step.cls.is_sign)
                neg_next = step.cls.is_minus;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= xtb_pkg::PH_BLANK;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            fidx_reg  <= '0;
            for (int i = 0; i < NA; i++)
                cap_reg[i] <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
            fidx_reg  <= fidx_next;
            for (int i = 0; i < NA; i++)
                cap_reg[i] <= cap_next[i];
        end
    end

endmodule

// ----- rtl/xtb_bounds_track.sv -----
// Running min/max per axis and smallest/second-smallest distinct x.
module xtb_bounds_track #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          line_fire,
    input  logic signed [COORD_WIDTH-1:0] pt        [xtb_pkg::NUM_AXES],
    output logic signed [COORD_WIDTH-1:0] low_next  [xtb_pkg::NUM_AXES],
    output logic signed [COORD_WIDTH-1:0] high_next [xtb_pkg::NUM_AXES],
    output logic        [COORD_WIDTH-1:0] grid_next
);

    localparam int NA = xtb_pkg::NUM_AXES;

    logic signed [COORD_WIDTH-1:0] low_reg  [NA];
    logic signed [COORD_WIDTH-1:0] high_reg [NA];
    logic signed [COORD_WIDTH-1:0] small_reg, small_next;
    logic signed [COORD_WIDTH-1:0] second_reg, second_next;
    logic                          first_reg, first_next;
    logic signed [COORD_WIDTH-1:0] x;

    assign x = pt[0];

    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            low_next[i]  = low_reg[i];
            high_next[i] = high_reg[i];
        end
        small_next  = small_reg;
        second_next = second_reg;
        first_next  = first_reg;

        if (line_fire)
        begin
            if (first_reg)
            begin
                for (int i = 0; i < NA; i++)
                begin
                    low_next[i]  = pt[i];
                    high_next[i] = pt[i];
                end
                small_next  = x;
                second_next = x;
                first_next  = 1'b0;
            end
            else
            begin
                for (int i = 0; i < NA; i++)
                begin
                    if (pt[i] < low_reg[i])
                        low_next[i] = pt[i];
                    if (high_reg[i] < pt[i])
                        high_next[i] = pt[i];
                end
                if (x < small_reg)
                begin
                    second_next = small_reg;
                    small_next  = x;
                end
                else if (x != small_reg)
                begin
                    // second equal to smallest means no second x yet
                    if ((second_reg == small_reg) || (x < second_reg))
                        second_next = x;
                end
            end
        end
        grid_next = $unsigned(second_next) - $unsigned(small_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NA; i++)
            begin
                low_reg[i]  <= '0;
                high_reg[i] <= '0;
            end
            small_reg  <= '0;
            second_reg <= '0;
            first_reg  <= 1'b1;
        end
        else
        begin
            for (int i = 0; i < NA; i++)
            begin
                low_reg[i]  <= low_next[i];
                high_reg[i] <= high_next[i];
            end
            small_reg  <= small_next;
            second_reg <= second_next;
            first_reg  <= first_next;
        end
    end

    a_bounds_x_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        !first_reg |-> (low_reg[0] <= high_reg[0]))
        else $error("x bounds out of order");

    a_bounds_y_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        !first_reg |-> (low_reg[1] <= high_reg[1]))
        else $error("y bounds out of order");

    a_small_is_min_x: assert property (@(posedge clk) disable iff (!rst_n)
        !first_reg |-> ((small_reg == low_reg[0]) && (small_reg <= second_reg)))
        else $error("smallest x does not track min x");

endmodule

// ----- rtl/xyz_text_bounds_scanner.sv -----
// Top level: input register, field parser, bounds tracker and result register.
// A newline that advances from the input register loads its result and raises out_valid.
// Throughput: one character per cycle while no newline stalls; the per-character digit
// multiply-add and the newline bound compares are combinational after the input register.
// A held result does not block characters; only a newline waiting behind it stalls.
// Reset (rst_n low, asynchronous): both registers empty, bounds armed for the first line.
module xyz_text_bounds_scanner #(
    parameter int COORD_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         char_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] point_x,
    output logic signed [31:0] point_y,
    output logic signed [31:0] point_z,
    output logic signed [31:0] min_x,
    output logic signed [31:0] min_y,
    output logic signed [31:0] min_z,
    output logic signed [31:0] max_x,
    output logic signed [31:0] max_y,
    output logic signed [31:0] max_z,
    output logic        [31:0] grid_step
);

    localparam int NA = xtb_pkg::NUM_AXES;

    logic                in_vld_reg, in_vld_next;
    logic [7:0]          byte_reg;
    logic                out_vld_reg, out_vld_next;
    logic                accept;
    logic                advance;
    logic                out_free;
    xtb_pkg::char_class_t cls;
    xtb_pkg::char_step_t  step;

    logic signed [31:0]  point_x_reg;
    logic signed [31:0]  point_y_reg;
    logic signed [31:0]  point_z_reg;
    logic signed [31:0]  min_x_reg;
    logic signed [31:0]  min_y_reg;
    logic signed [31:0]  min_z_reg;
    logic signed [31:0]  max_x_reg;
    logic signed [31:0]  max_y_reg;
    logic signed [31:0]  max_z_reg;
    logic        [31:0]  grid_step_reg;

    logic                          line_fire;
    logic signed [COORD_WIDTH-1:0] pt        [NA];
    logic signed [COORD_WIDTH-1:0] low_next  [NA];
    logic signed [COORD_WIDTH-1:0] high_next [NA];
    logic        [COORD_WIDTH-1:0] grid_next;

    assign cls      = xtb_pkg::classify(byte_reg);
    assign out_free = !out_vld_reg || !out_stall;
    assign advance  = in_vld_reg && (!cls.is_newline || out_free);
    assign in_stall = in_vld_reg && !advance;
    assign accept   = in_valid && !in_stall;

    assign step.fire  = advance;
    assign step.cls   = cls;
    assign step.digit = byte_reg[3:0];

    assign in_vld_next  = accept ? 1'b1 : (advance ? 1'b0 : in_vld_reg);
    assign out_vld_next = line_fire ? 1'b1 : (out_free ? 1'b0 : out_vld_reg);
    assign out_valid    = out_vld_reg;

    assign point_x   = point_x_reg;
    assign point_y   = point_y_reg;
    assign point_z   = point_z_reg;
    assign min_x     = min_x_reg;
    assign min_y     = min_y_reg;
    assign min_z     = min_z_reg;
    assign max_x     = max_x_reg;
    assign max_y     = max_y_reg;
    assign max_z     = max_z_reg;
    assign grid_step = grid_step_reg;

    xtb_field_parser #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .line_fire (line_fire),
        .pt        (pt)
    );

    xtb_bounds_track #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_bounds (
        .clk       (clk),
        .rst_n     (rst_n),
        .line_fire (line_fire),
        .pt        (pt),
        .low_next  (low_next),
        .high_next (high_next),
        .grid_next (grid_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            byte_reg <= char_byte;
        if (line_fire)
        begin
            point_x_reg   <= 32'(pt[0]);
            point_y_reg   <= 32'(pt[1]);
            point_z_reg   <= 32'(pt[2]);
            min_x_reg     <= 32'(low_next[0]);
            min_y_reg     <= 32'(low_next[1]);
            min_z_reg     <= 32'(low_next[2]);
            max_x_reg     <= 32'(high_next[0]);
            max_y_reg     <= 32'(high_next[1]);
            max_z_reg     <= 32'(high_next[2]);
            grid_step_reg <= 32'(grid_next);
        end
    end

    a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_vld_reg && cls.is_newline && out_vld_reg))
        else $error("input stalled without a blocked newline");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        line_fire |-> out_free)
        else $error("result register overwritten while held");

    a_line_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        line_fire |=> out_valid)
        else $error("newline produced no result");

    a_request_lands: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_vld_reg)
        else $error("accepted request lost from input register");

endmodule

// ----- tb/tb.sv -----
// Testbench for xyz_text_bounds_scanner: random x y z text checked line by line.
typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] min_z;
    logic signed [31:0] max_x;
    logic signed [31:0] max_y;
    logic signed [31:0] max_z;
    logic        [31:0] grid_step;
} point_t;

class bounds_scoreboard;
    point_t             line_q[$];
    logic        [31:0] acc;
    logic               neg;
    xtb_pkg::phase_t    phase;
    int                 fidx;
    logic signed [31:0] fld [3];
    logic signed [31:0] lo [3];
    logic signed [31:0] hi [3];
    logic signed [31:0] sx;
    logic signed [31:0] sec;
    bit                 first;
    int                 errors;
    int                 checked;

    function new();
        acc = '0;
        neg = 1'b0;
        phase = xtb_pkg::PH_BLANK;
        fidx = 0;
        for (int i = 0; i < 3; i++)
        begin
            fld[i] = '0;
            lo[i] = '0;
            hi[i] = '0;
        end
        sx = '0;
        sec = '0;
        first = 1'b1;
        errors = 0;
        checked = 0;
    endfunction

    task report(string msg);
        errors++;
        if (errors <= 40)
            $display("ERROR: %s", msg);
    endtask

    function int pending();
        return line_q.size();
    endfunction

    function void close_field();
        if (fidx < 3)
        begin
            fld[fidx] = neg ? -acc : acc;
            fidx++;
        end
        acc = '0;
        neg = 1'b0;
        phase = xtb_pkg::PH_BLANK;
    endfunction

    function void note_char(logic [7:0] c);
        point_t             p;
        logic signed [31:0] x;
        bit                 is_digit;
        bit                 is_blank;
        bit                 is_sign;
        is_digit = (c >= xtb_pkg::CH_ZERO) && (c <= xtb_pkg::CH_NINE);
        is_blank = (c == xtb_pkg::CH_SPACE) || (c == xtb_pkg::CH_VTAB) ||
                   (c == xtb_pkg::CH_FFEED) || (c == xtb_pkg::CH_CR);
        is_sign  = (c == xtb_pkg::CH_PLUS) || (c == xtb_pkg::CH_MINUS);
        if (c == xtb_pkg::CH_TAB)
        begin
            close_field();
            return;
        end
        if (c != xtb_pkg::CH_NEWLINE)
        begin
            if (phase == xtb_pkg::PH_STOP)
                return;
            if (is_digit)
            begin
                acc = acc * 32'd10 + 32'(c - xtb_pkg::CH_ZERO);
                phase = xtb_pkg::PH_DIGIT;
            end
            else if (phase == xtb_pkg::PH_BLANK && is_blank)
            begin
            end
            else if (phase == xtb_pkg::PH_BLANK && is_sign)
            begin
                neg = (c == xtb_pkg::CH_MINUS);
                phase = xtb_pkg::PH_SIGN;
            end
            else
                phase = xtb_pkg::PH_STOP;
            return;
        end
        close_field();
        x = fld[0];
        if (first)
        begin
            for (int i = 0; i < 3; i++)
            begin
                lo[i] = fld[i];
                hi[i] = fld[i];
            end
            sx = x;
            sec = x;
            first = 1'b0;
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (fld[i] < lo[i])
                    lo[i] = fld[i];
                if (hi[i] < fld[i])
                    hi[i] = fld[i];
            end
            if (x < sx)
            begin
                sec = sx;
                sx = x;
            end
            else if (x != sx)
            begin
                if (sec == sx || x < sec)
                    sec = x;
            end
        end
        p.point_x = fld[0];
        p.point_y = fld[1];
        p.point_z = fld[2];
        p.min_x = lo[0];
        p.min_y = lo[1];
        p.min_z = lo[2];
        p.max_x = hi[0];
        p.max_y = hi[1];
        p.max_z = hi[2];
        p.grid_step = sec - sx;
        line_q.push_back(p);
        for (int i = 0; i < 3; i++)
            fld[i] = '0;
        fidx = 0;
    endfunction

    task cmp(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report($sformatf("line %0d %s got %0h expected %0h", checked, name, got, want));
    endtask

    task check_point(point_t got);
        point_t want;
        if (line_q.size() == 0)
        begin
            report("result with no pending line");
            return;
        end
        want = line_q.pop_front();
        checked++;
        cmp("point_x", got.point_x, want.point_x);
        cmp("point_y", got.point_y, want.point_y);
        cmp("point_z", got.point_z, want.point_z);
        cmp("min_x", got.min_x, want.min_x);
        cmp("min_y", got.min_y, want.min_y);
        cmp("min_z", got.min_z, want.min_z);
        cmp("max_x", got.max_x, want.max_x);
        cmp("max_y", got.max_y, want.max_y);
        cmp("max_z", got.max_z, want.max_z);
        cmp("grid_step", got.grid_step, want.grid_step);
    endtask
endclass

module tb;
    localparam int CYCLE_LIMIT = 200000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         char_byte = 8'h00;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] min_z;
    logic signed [31:0] max_x;
    logic signed [31:0] max_y;
    logic signed [31:0] max_z;
    logic        [31:0] grid_step;

    bounds_scoreboard sb = new();
    point_t           seen;
    logic [7:0]       line_buf[$];
    int               send_idle = 16;
    int               recv_idle = 59;
    bit               long_hold = 1'b0;
    int               cycles = 0;
    int               sent = 0;

    xyz_text_bounds_scanner dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_byte (char_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .point_x   (point_x),
        .point_y   (point_y),
        .point_z   (point_z),
        .min_x     (min_x),
        .min_y     (min_y),
        .min_z     (min_z),
        .max_x     (max_x),
        .max_y     (max_y),
        .max_z     (max_z),
        .grid_step (grid_step)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_char(char_byte);
        if (rst_n && out_valid && !out_stall)
        begin
            seen.point_x = point_x;
            seen.point_y = point_y;
            seen.point_z = point_z;
            seen.min_x = min_x;
            seen.min_y = min_y;
            seen.min_z = min_z;
            seen.max_x = max_x;
            seen.max_y = max_y;
            seen.max_z = max_z;
            seen.grid_step = grid_step;
            sb.check_point(seen);
        end
    end

    always @(negedge clk)
    begin
        if (long_hold)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99) < recv_idle);
    end

    task automatic send_byte(input logic [7:0] c);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        char_byte <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    task automatic send_line();
        foreach (line_buf[i])
            send_byte(line_buf[i]);
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(3))
            0: return xtb_pkg::CH_SPACE;
            1: return xtb_pkg::CH_VTAB;
            2: return xtb_pkg::CH_FFEED;
            default: return xtb_pkg::CH_CR;
        endcase
    endfunction

    task automatic add_field(input bit broken);
        string s;
        int    n;
        n = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
        repeat (n)
            line_buf.push_back(pick_blank());
        case ($urandom_range(9))
            0, 1, 2: line_buf.push_back(xtb_pkg::CH_MINUS);
            3: line_buf.push_back(xtb_pkg::CH_PLUS);
            default: ;
        endcase
        if (broken && $urandom_range(2) == 0)
            line_buf.push_back($urandom_range(1) ? pick_blank() :
                               ($urandom_range(1) ? xtb_pkg::CH_PLUS : xtb_pkg::CH_MINUS));
        case ($urandom_range(9))
            0, 1, 2, 3, 4: s = $sformatf("%0d", $urandom_range(20));
            5: s = $sformatf("%0d", $urandom);
            6:
            begin
                case ($urandom_range(5))
                    0: s = "2147483647";
                    1: s = "2147483648";
                    2: s = "4294967295";
                    3: s = "4294967296";
                    4: s = "99999999999";
                    default: s = "0";
                endcase
            end
            7:
            begin
                s = "";
                repeat ($urandom_range(10, 14))
                    s = {s, $sformatf("%0d", $urandom_range(9))};
            end
            8: s = "";
            default: s = $sformatf("%0d", $urandom_range(999));
        endcase
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
        if (broken)
        begin
            line_buf.push_back(8'($urandom_range(255)));
            if ($urandom_range(1))
                line_buf.push_back(xtb_pkg::CH_ZERO + 8'($urandom_range(9)));
        end
    endtask

    task automatic gen_line();
        int  kind;
        int  nf;
        bit  broken;
        line_buf.delete();
        kind = $urandom_range(99);
        if (kind < 12)
        begin
            repeat ($urandom_range(1, 12))
                line_buf.push_back(8'($urandom_range(255)));
        end
        else
        begin
            broken = (kind >= 80 && kind < 92);
            nf = (kind < 80) ? 3 : $urandom_range(0, 5);
            for (int f = 0; f < nf; f++)
            begin
                if (f > 0)
                    line_buf.push_back(xtb_pkg::CH_TAB);
                add_field(broken && $urandom_range(1));
            end
        end
        line_buf.push_back(xtb_pkg::CH_NEWLINE);
    endtask

    task automatic run_random(input int count);
        int target;
        target = sent + count;
        while (sent < target)
        begin
            gen_line();
            send_line();
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty first line, signs, leading blank, extra field, repeated x,
        // second sign, blank and high byte after digits
        line_buf = '{xtb_pkg::CH_NEWLINE,
                     xtb_pkg::CH_MINUS, xtb_pkg::CH_ZERO + 8'd7, xtb_pkg::CH_TAB,
                     xtb_pkg::CH_PLUS, xtb_pkg::CH_ZERO + 8'd3, xtb_pkg::CH_TAB,
                     xtb_pkg::CH_SPACE, xtb_pkg::CH_ZERO + 8'd2, xtb_pkg::CH_TAB,
                     xtb_pkg::CH_ZERO + 8'd9, xtb_pkg::CH_NEWLINE,
                     xtb_pkg::CH_MINUS, xtb_pkg::CH_ZERO + 8'd7, xtb_pkg::CH_TAB,
                     xtb_pkg::CH_PLUS, xtb_pkg::CH_MINUS, xtb_pkg::CH_ZERO + 8'd4,
                     xtb_pkg::CH_NEWLINE,
                     xtb_pkg::CH_ZERO + 8'd3, xtb_pkg::CH_SPACE, xtb_pkg::CH_ZERO + 8'd5,
                     8'hFF, xtb_pkg::CH_NEWLINE};
        send_line();

        run_random(460);
        wait_drained();

        send_idle = 59;
        recv_idle = 16;
        run_random(480);
        wait_drained();

        send_idle = 0;
        recv_idle = 0;
        fork
            begin
                @(posedge clk);
                long_hold = 1'b1;
                repeat (300)
                    @(posedge clk);
                long_hold = 1'b0;
            end
        join_none
        run_random(490);
        wait_drained();
        repeat (6)
            @(posedge clk);

        $display("Sent %0d characters, checked %0d lines", sent, sb.checked);
        $display("Idle mixes: sender-light, receiver-light, none; one 300-cycle output hold");
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
